[sv/zeck_pkg.sv]
// Package for the Zeckendorf converter: default sizes and the Fibonacci weight function.
// No dependencies; imported by zeck_stage and zeckendorf_converter.
`default_nettype none

package zeck_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_DIGIT_COUNT = 46;
    localparam int WEIGHT_WIDTH    = 64;

    // Weight of digit idx: 1, 2, 3, 5, 8, ... saturating at the 64-bit maximum.
    function automatic logic [WEIGHT_WIDTH-1:0] fib_weight(input int idx);
        logic [WEIGHT_WIDTH-1:0] a;
        logic [WEIGHT_WIDTH-1:0] b;
        logic [WEIGHT_WIDTH:0]   s;
        int k;
        a = WEIGHT_WIDTH'(1);
        b = WEIGHT_WIDTH'(2);
        if (idx == 0) begin
            return a;
        end
        for (k = 2; k <= idx; k++) begin
            s = {1'b0, a} + {1'b0, b};
            a = b;
            b = s[WEIGHT_WIDTH] ? {WEIGHT_WIDTH{1'b1}} : s[WEIGHT_WIDTH-1:0];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[sv/zeck_stage.sv]
// One pipeline stage of the converter: compare-subtract against a single constant weight.
// Depends on zeck_pkg for the weight function.
`default_nettype none

module zeck_stage
    import zeck_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int DIGIT_COUNT = DEF_DIGIT_COUNT,
    parameter int CNT_WIDTH   = $clog2(DEF_DIGIT_COUNT + 1),
    parameter int INDEX       = 0
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [VALUE_WIDTH-1:0] in_rem,
    input  wire logic [DIGIT_COUNT-1:0] in_digs,
    input  wire logic [CNT_WIDTH-1:0]   in_count,
    input  wire logic                   in_found,
    output logic                        valid_reg,
    output logic [VALUE_WIDTH-1:0]      rem_reg,
    output logic [DIGIT_COUNT-1:0]      digs_reg,
    output logic [CNT_WIDTH-1:0]        count_reg,
    output logic                        found_reg
);

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT = fib_weight(INDEX);

    logic [WEIGHT_WIDTH-1:0] rem_ext;
    logic                    hit;
    logic [VALUE_WIDTH-1:0]  rem_next;
    logic [DIGIT_COUNT-1:0]  digs_next;
    logic [CNT_WIDTH-1:0]    count_next;
    logic                    found_next;

    assign rem_ext = WEIGHT_WIDTH'(in_rem);
    // Weights are at least one, so a hit also means a nonzero remainder.
    assign hit     = (rem_ext >= WEIGHT);

    always_comb begin
        rem_next   = in_rem;
        digs_next  = in_digs;
        count_next = in_count;
        found_next = in_found;
        if (hit) begin
            rem_next = in_rem - WEIGHT[VALUE_WIDTH-1:0];
            if (INDEX < WEIGHT_WIDTH) begin
                digs_next[INDEX] = 1'b1;
            end
            if (!in_found) begin
                found_next = 1'b1;
                count_next = CNT_WIDTH'(INDEX + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            digs_reg  <= digs_next;
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

[sv/zeckendorf_converter.sv]
// Path from input accept to m_tvalid: the first weight stage, then each later stage in
// turn, then the output register; the chain holds while the skid register is occupied.
// Throughput: one item per cycle while the skid register is empty.
// One compare-subtract stage per Fibonacci weight.
// Output register plus skid register decouple m_tready from the stage chain.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers keep content.
// Top level of the Zeckendorf converter; depends on zeck_pkg and zeck_stage.
`default_nettype none

module zeckendorf_converter
    import zeck_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // value
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // digits, digit_count
    output logic [((DIGIT_COUNT + $clog2(DIGIT_COUNT + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CNT_WIDTH = $clog2(DIGIT_COUNT + 1);
    localparam int OUT_WIDTH = ((DIGIT_COUNT + CNT_WIDTH + 7) / 8) * 8;

    // Stage k handles weight index DIGIT_COUNT-1-k, highest weight first.
    logic                   st_valid [DIGIT_COUNT];
    logic [VALUE_WIDTH-1:0] st_rem   [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] st_digs  [DIGIT_COUNT];
    logic [CNT_WIDTH-1:0]   st_count [DIGIT_COUNT];
    logic                   st_found [DIGIT_COUNT];

    logic                   pipe_en;

    logic                   out_valid_reg;
    logic [DIGIT_COUNT-1:0] out_digs_reg;
    logic [CNT_WIDTH-1:0]   out_count_reg;
    logic                   skid_valid_reg;
    logic [DIGIT_COUNT-1:0] skid_digs_reg;
    logic [CNT_WIDTH-1:0]   skid_count_reg;

    // Advance the whole chain unless a result is parked in the skid register.
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    genvar k;
    generate
        for (k = 0; k < DIGIT_COUNT; k++) begin : g_stage
            if (k == 0) begin : g_first
                // Enter with the full value, no digits, count 1 for the zero case.
                zeck_stage #(
                    .VALUE_WIDTH (VALUE_WIDTH),
                    .DIGIT_COUNT (DIGIT_COUNT),
                    .CNT_WIDTH   (CNT_WIDTH),
                    .INDEX       (DIGIT_COUNT - 1 - k)
                ) u_stage (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (pipe_en),
                    .in_valid  (s_tvalid),
                    .in_rem    (s_tdata[VALUE_WIDTH-1:0]),
                    .in_digs   ({DIGIT_COUNT{1'b0}}),
                    .in_count  (CNT_WIDTH'(1)),
                    .in_found  (1'b0),
                    .valid_reg (st_valid[k]),
                    .rem_reg   (st_rem[k]),
                    .digs_reg  (st_digs[k]),
                    .count_reg (st_count[k]),
                    .found_reg (st_found[k])
                );
            end else begin : g_next
                zeck_stage #(
                    .VALUE_WIDTH (VALUE_WIDTH),
                    .DIGIT_COUNT (DIGIT_COUNT),
                    .CNT_WIDTH   (CNT_WIDTH),
                    .INDEX       (DIGIT_COUNT - 1 - k)
                ) u_stage (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (pipe_en),
                    .in_valid  (st_valid[k-1]),
                    .in_rem    (st_rem[k-1]),
                    .in_digs   (st_digs[k-1]),
                    .in_count  (st_count[k-1]),
                    .in_found  (st_found[k-1]),
                    .valid_reg (st_valid[k]),
                    .rem_reg   (st_rem[k]),
                    .digs_reg  (st_digs[k]),
                    .count_reg (st_count[k]),
                    .found_reg (st_found[k])
                );
            end
        end
    endgenerate

    // Output register with skid: a finished item goes to the output register when it is
    // free or being taken, else park it in the skid register and hold the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (st_valid[DIGIT_COUNT-1]) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_digs_reg  <= skid_digs_reg;
                out_count_reg <= skid_count_reg;
            end
        end else if (st_valid[DIGIT_COUNT-1]) begin
            if (!out_valid_reg || m_tready) begin
                out_digs_reg  <= st_digs[DIGIT_COUNT-1];
                out_count_reg <= st_count[DIGIT_COUNT-1];
            end else begin
                skid_digs_reg  <= st_digs[DIGIT_COUNT-1];
                skid_count_reg <= st_count[DIGIT_COUNT-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'({out_count_reg, out_digs_reg});

    // A parked item implies the output register is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while output register is empty");

    // Digit count stays within 1..DIGIT_COUNT.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_count_reg >= CNT_WIDTH'(1)
                           && out_count_reg <= CNT_WIDTH'(DIGIT_COUNT)))
        else $error("digit count out of range");

    // No digit is set above the top digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_digs_reg >> out_count_reg) == '0))
        else $error("digit set above digit count");

    // Top digit named by the count is set if count is above one and at most WEIGHT_WIDTH.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_count_reg > CNT_WIDTH'(1)
            && int'(out_count_reg) <= WEIGHT_WIDTH
            |-> ((out_digs_reg >> (out_count_reg - CNT_WIDTH'(1))) == DIGIT_COUNT'(1)))
        else $error("top digit missing for digit count");

endmodule

`default_nettype wire
